FILE: sv/smx_pkg.sv
// Package for the softmax block: widths, capacity, exponent table and control structs.
// Used by smx_datapath, smx_ctrl and softmax_vector.
package smx_pkg;

  localparam int unsigned MaxLen   = 64;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned SumW     = 24;
  localparam int unsigned QuotW    = 17;
  localparam logic [15:0] Log2eQ15 = 16'd47274;

  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    begin
      case (k)
        5'd0:    v = 17'd65536;
        5'd1:    v = 17'd62757;
        5'd2:    v = 17'd60097;
        5'd3:    v = 17'd57549;
        5'd4:    v = 17'd55109;
        5'd5:    v = 17'd52773;
        5'd6:    v = 17'd50535;
        5'd7:    v = 17'd48393;
        5'd8:    v = 17'd46341;
        5'd9:    v = 17'd44376;
        5'd10:   v = 17'd42495;
        5'd11:   v = 17'd40693;
        5'd12:   v = 17'd38968;
        5'd13:   v = 17'd37316;
        5'd14:   v = 17'd35734;
        5'd15:   v = 17'd34219;
        5'd16:   v = 17'd32768;
        default: v = 17'd32768;
      endcase
      return v;
    end
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;      // store an accepted score
    logic             clear;     // return running state to reset values
    logic             exp_start; // start the exponential for an element
    logic             div_start; // start the division for an element
    logic [AddrW-1:0] addr;      // element being processed
  } smx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              exp_done;
    logic              div_done;
    logic [CountW-1:0] count;
    logic              dropped;
    logic [15:0]       prob;
  } smx_sts_t;

endpackage

FILE: sv/smx_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module smx_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: sv/smx_datapath.sv
// Datapath of the softmax block: stores, running max, exponential pipe, sum, divider.
// Depends on smx_pkg and smx_ram.
module smx_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smx_pkg::smx_cmd_t cmd_i,
  input  logic [15:0]       score_i,
  output smx_pkg::smx_sts_t sts_o
);
  logic [15:0] score_rd, exp_rd;
  logic signed [15:0] max_q;
  logic [smx_pkg::CountW-1:0] count_q;
  logic drop_q;
  logic [smx_pkg::SumW-1:0] sum_q;
  logic full;
  logic exp_we;
  logic [15:0] exp_val;
  logic [smx_pkg::AddrW-1:0] sc_addr;

  assign full = (count_q == smx_pkg::CountW'(smx_pkg::MaxLen));
  assign sc_addr = cmd_i.load ? count_q[smx_pkg::AddrW-1:0] : cmd_i.addr;

  smx_ram #(.Width(16), .Depth(smx_pkg::MaxLen)) u_score (
    .clk_i(clk_i), .we_i(cmd_i.load && !full), .addr_i(sc_addr),
    .wdata_i(score_i), .rdata_o(score_rd)
  );
  smx_ram #(.Width(16), .Depth(smx_pkg::MaxLen)) u_exp (
    .clk_i(clk_i), .we_i(exp_we), .addr_i(cmd_i.addr),
    .wdata_i(exp_val), .rdata_o(exp_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= 16'sh8000;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.clear) begin
      max_q   <= 16'sh8000;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.load) begin
      if (full) begin
        drop_q <= 1'b1;
      end else begin
        count_q <= count_q + 1'b1;
        if ($signed(score_i) > max_q) begin
          max_q <= $signed(score_i);
        end
      end
    end
  end

  // Exponential pipe: RAM read, diff, multiply, table lookup, interpolate, shift.
  // The result register is written back to the exponent RAM in the cycle after the shift stage.
  logic [5:0] ep_q;
  logic [15:0] d_q;
  logic [31:0] y_q;
  logic [16:0] hi_q, lo_q;
  logic [11:0] r_q;
  logic [6:0]  n_q, n2_q;
  logic [16:0] v_q;
  logic [16:0] diff;
  logic [28:0] prod;
  logic [47:0] shifted;
  logic [16:0] e_full;
  logic [15:0] ex_q;

  assign diff  = hi_q - lo_q;
  assign prod  = diff * r_q + 29'd2048;
  assign shifted = ({31'd0, v_q} + ((n2_q == 7'd0) ? 48'd0 : (48'd1 << (n2_q - 7'd1))))
                   >> n2_q;
  assign e_full = (n2_q == 7'd0) ? v_q : (n2_q >= 7'd32) ? 17'd0 : shifted[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep_q <= '0;
    end else begin
      ep_q <= {ep_q[4:0], cmd_i.exp_start};
    end
  end

  always_ff @(posedge clk_i) begin
    d_q  <= 16'(max_q - $signed(score_rd));
    y_q  <= d_q * smx_pkg::Log2eQ15;
    hi_q <= smx_pkg::pow2_neg({1'b0, y_q[24:21]});
    lo_q <= smx_pkg::pow2_neg(5'({1'b0, y_q[24:21]} + 5'd1));
    r_q  <= y_q[20:9];
    n_q  <= {y_q[31:25]};
    v_q  <= hi_q - 17'(prod >> 12);
    n2_q <= n_q;
    ex_q <= e_full[16] ? 16'hFFFF : e_full[15:0];
  end
  assign exp_we  = ep_q[5];
  assign exp_val = ex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.clear) begin
      sum_q <= '0;
    end else if (exp_we) begin
      sum_q <= sum_q + smx_pkg::SumW'(ex_q);
    end
  end

  // Restoring divider: one quotient bit a cycle; numerator e*65536 + sum/2.
  logic [40:0] num_q;
  logic [smx_pkg::SumW:0] rem_q;
  logic [5:0] dcnt_q;
  logic dbusy_q, ddone_q, dload_q;
  logic [smx_pkg::SumW:0] trial;
  logic [smx_pkg::QuotW+23:0] quot_q;

  assign trial = {rem_q[smx_pkg::SumW-1:0], num_q[40]} - {1'b0, sum_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dload_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      ddone_q <= 1'b0;
      dload_q <= cmd_i.div_start;
      if (dload_q) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= 6'd41;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - 6'd1;
        if (dcnt_q == 6'd1) begin
          dbusy_q <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dload_q) begin
      num_q  <= 41'({exp_rd, 16'd0}) + 41'(sum_q >> 1);
      rem_q  <= '0;
      quot_q <= '0;
    end else if (dbusy_q) begin
      num_q <= {num_q[39:0], 1'b0};
      if (!trial[smx_pkg::SumW]) begin
        rem_q  <= trial;
        quot_q <= {quot_q[39:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[smx_pkg::SumW-1:0], num_q[40]};
        quot_q <= {quot_q[39:0], 1'b0};
      end
    end
  end

  // The quotient never exceeds 17 bits since each exponential is at most the sum.
  logic [32:0] q_adj;
  assign q_adj = 33'(quot_q);

  assign sts_o.exp_done = exp_we;
  assign sts_o.div_done = ddone_q;
  assign sts_o.count    = count_q;
  assign sts_o.dropped  = drop_q;
  assign sts_o.prob     = (q_adj > 33'd65535) ? 16'hFFFF : q_adj[15:0];
endmodule

FILE: sv/smx_ctrl.sv
// Controller of the softmax block: load, exponentiate, divide and emit sequencing.
// Depends on smx_pkg.
module smx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  smx_pkg::smx_sts_t sts_i,
  output smx_pkg::smx_cmd_t cmd_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       out_prob_o,
  output logic              out_last_o,
  output logic              out_drop_o
);
  typedef enum logic [2:0] {
    S_LOAD, S_EXP, S_EXPWAIT, S_DIV, S_DIVWAIT, S_EMIT
  } state_e;

  state_e state_q;
  logic [smx_pkg::CountW-1:0] idx_q;
  logic [smx_pkg::CountW-1:0] last_idx;
  logic load_go;

  assign in_ready_o = (state_q == S_LOAD);
  assign load_go    = in_valid_i && in_ready_o;
  assign last_idx   = sts_i.count - 1'b1;

  always_comb begin
    cmd_o           = '0;
    cmd_o.addr      = idx_q[smx_pkg::AddrW-1:0];
    cmd_o.load      = load_go;
    cmd_o.exp_start = (state_q == S_EXP);
    cmd_o.div_start = (state_q == S_DIV);
    cmd_o.clear     = (state_q == S_EMIT) && out_ready_i && (idx_q == last_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      idx_q       <= '0;
      out_valid_o <= 1'b0;
      out_prob_o  <= '0;
      out_last_o  <= 1'b0;
      out_drop_o  <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          idx_q <= '0;
          if (load_go && in_last_i) begin
            state_q <= S_EXP;
          end
        end
        S_EXP: begin
          if (sts_i.count == '0) begin
            state_q <= S_LOAD;
          end else begin
            state_q <= S_EXPWAIT;
          end
        end
        S_EXPWAIT: begin
          if (sts_i.exp_done) begin
            if (idx_q == last_idx) begin
              idx_q   <= '0;
              state_q <= S_DIV;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_EXP;
            end
          end
        end
        S_DIV: state_q <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (sts_i.div_done) begin
            out_valid_o <= 1'b1;
            out_prob_o  <= sts_i.prob;
            out_last_o  <= (idx_q == last_idx);
            out_drop_o  <= sts_i.dropped;
            state_q     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            if (idx_q == last_idx) begin
              state_q <= S_LOAD;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_DIV;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule

FILE: sv/softmax_vector.sv
// Top level of the softmax block: stream ports, controller and datapath.
// Depends on smx_pkg, smx_ctrl and smx_datapath.
//
// Usage: scores stream in on the s_axis channel, one signed Q5.10 value per
// transaction; tlast closes the vector. Up to 64 scores are kept; further
// scores are dropped and every result of that vector carries the overflow flag.
// Loading accepts one transaction per cycle while s_axis_tready is high. After
// the closing transaction the block computes exp(score - max) for each element
// through the exponent pipeline, one element at a time, then divides each by
// the sum with a bit-serial divider, each result held in the output register.
// Results leave on m_axis in load order, the final one with tlast set.
// While a vector is being processed s_axis_tready is low; it rises again once
// the last result transaction is taken. A stalled receiver simply holds the
// block in its output state with the result steady. Reset returns the block
// to the loading state with an empty vector.
module softmax_vector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // score
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // probability
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // overflowed
);
  smx_pkg::smx_cmd_t cmd;
  smx_pkg::smx_sts_t sts;

  smx_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .in_last_i(s_axis_tlast), .in_ready_o(s_axis_tready),
    .sts_i(sts), .cmd_o(cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_prob_o(m_axis_tdata), .out_last_o(m_axis_tlast), .out_drop_o(m_axis_tuser)
  );

  smx_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .score_i(s_axis_tdata), .sts_o(sts)
  );
endmodule
